// ===== src/mdbc_pkg.sv =====
// Shared constants, color stops and log table builder for the magnitude dB colormap.
package mdbc_pkg;

  // Input format
  localparam int MAG_W          = 32;
  localparam int MAG_FRAC_BITS  = 24;
  localparam int LOG_TABLE_BITS = 8;
  localparam int ROM_DEPTH      = 1 << LOG_TABLE_BITS;
  localparam int POS_W          = $clog2(MAG_W);

  // Negative log2 in Q16: integer part is the exponent distance to 1.0
  localparam int EXP_W       = $clog2(MAG_FRAC_BITS + 1);
  localparam int LOG_FRAC_W  = 16;
  localparam int NLOG_W      = EXP_W + LOG_FRAC_W;

  // 20*log10(2) in Q16, product shifted down by 24 gives dB in Q8.8
  localparam int                 DB_SCALE_W      = 19;
  localparam logic [DB_SCALE_W-1:0] DB_PER_LOG2_Q16 = DB_SCALE_W'(394566);
  localparam int                 PROD_W          = NLOG_W + DB_SCALE_W;
  localparam int                 PROD_SHIFT      = 24;
  localparam int                 RAW_W           = PROD_W - PROD_SHIFT;

  // Level and loss
  localparam int               LOSS_W   = 15;
  localparam logic [LOSS_W-1:0] LOSS_MAX = LOSS_W'(25600);
  localparam int               LEVEL_W  = 16;

  // Gradient: four quarters of 6400 (Q8.8 of 25 dB)
  localparam int                 SEG_W    = 2;
  localparam int                 POS_IN_W = 13;
  localparam logic [LOSS_W-1:0]  QUARTER  = LOSS_W'(6400);
  localparam int                 CH_W     = 8;
  localparam int                 NUM_CH   = 3;
  localparam int                 MIX_W    = 21;

  // x / 6400 = (x >> 8) / 25, and y / 25 = (y * 20972) >> 19 for y < 43690
  localparam int                 QUO_SHIFT   = 8;
  localparam int                 Y_W         = MIX_W - QUO_SHIFT;
  localparam int                 RECIP_W     = 15;
  localparam logic [RECIP_W-1:0] RECIP_25    = RECIP_W'(20972);
  localparam int                 RECIP_SHIFT = 19;
  localparam int                 QUO_W       = Y_W + RECIP_W;

  // Stops: dark purple, purple, red, orange, yellow; channel order r, g, b
  localparam logic [CH_W-1:0] STOP_RGB [5][NUM_CH] = '{
    '{8'h12, 8'h00, 8'h2B},
    '{8'h3B, 8'h07, 8'h64},
    '{8'hBE, 8'h12, 8'h3C},
    '{8'hF9, 8'h73, 8'h16},
    '{8'hFA, 8'hCC, 8'h15}
  };

  // log2(1 + idx/2^LOG_TABLE_BITS) as 16 fraction bits, by repeated squaring.
  // Evaluated at elaboration only.
  function automatic logic [LOG_FRAC_W-1:0] log_rom_f(input int unsigned idx);
    logic [63:0]           x;
    logic [LOG_FRAC_W-1:0] f;
    x = (64'd1 << 30) + (64'(idx % ROM_DEPTH) << (30 - LOG_TABLE_BITS));
    f = '0;
    for (int k = 0; k < LOG_FRAC_W; k++) begin
      x = (x * x) >> 30;
      f = f << 1;
      if (x >= (64'd2 << 30)) begin
        f[0] = 1'b1;
        x    = x >> 1;
      end
    end
    return f;
  endfunction

endpackage

// ===== src/mdbc_log.sv =====
// Four-stage magnitude to dB loss pipeline: leading one, normalize, log table, scale.
module mdbc_log (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mdbc_pkg::MAG_W-1:0]    mag_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mdbc_pkg::LOSS_W-1:0]   loss_o
);
  import mdbc_pkg::*;

  logic [3:0] vld_q;
  logic [3:0] en;

  // stage 1: leading one
  logic [MAG_W-1:0] s1_mag_q;
  logic [POS_W-1:0] s1_pos_q, s1_pos_d;
  logic             s1_zero_q;
  // stage 2: normalize
  logic [LOG_TABLE_BITS-1:0] s2_idx_q, s2_idx_d;
  logic [EXP_W-1:0]          s2_exp_q, s2_exp_d;
  logic                      s2_zero_q, s2_big_q, s2_big_d;
  logic [MAG_W-1:0]          norm;
  logic [POS_W:0]            exp_full;
  // stage 3: log table
  logic [NLOG_W-1:0] s3_nlog_q, s3_nlog_d;
  logic              s3_zero_q, s3_big_q;
  logic [LOG_FRAC_W-1:0] rom [ROM_DEPTH];
  // stage 4: scale
  logic [PROD_W-1:0] s4_prod_q, s4_prod_d;
  logic              s4_zero_q, s4_big_q;

  for (genvar i = 0; i < ROM_DEPTH; i++) begin : g_rom
    assign rom[i] = log_rom_f(i);
  end

  always_comb begin
    en[3] = ~vld_q[3] | out_ready_i;
    en[2] = ~vld_q[2] | en[3];
    en[1] = ~vld_q[1] | en[2];
    en[0] = ~vld_q[0] | en[1];
  end
  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      if (en[1]) vld_q[1] <= vld_q[0];
      if (en[2]) vld_q[2] <= vld_q[1];
      if (en[3]) vld_q[3] <= vld_q[2];
    end
  end

  always_comb begin
    s1_pos_d = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (mag_i[b]) s1_pos_d = POS_W'(b);
    end
  end

  always_comb begin
    norm     = s1_mag_q << (POS_W'(MAG_W - 1) - s1_pos_q);
    s2_idx_d = norm[MAG_W-2 -: LOG_TABLE_BITS];
    s2_big_d = ({1'b0, s1_pos_q} >= (POS_W+1)'(MAG_FRAC_BITS));
    exp_full = (POS_W+1)'(MAG_FRAC_BITS) - {1'b0, s1_pos_q};
    s2_exp_d = exp_full[EXP_W-1:0];
  end

  assign s3_nlog_d = {s2_exp_q, {LOG_FRAC_W{1'b0}}} - {{EXP_W{1'b0}}, rom[s2_idx_q]};
  assign s4_prod_d = PROD_W'(s3_nlog_q) * PROD_W'(DB_PER_LOG2_Q16);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_mag_q  <= mag_i;
      s1_pos_q  <= s1_pos_d;
      s1_zero_q <= (mag_i == '0);
    end
    if (en[1]) begin
      s2_idx_q  <= s2_idx_d;
      s2_exp_q  <= s2_exp_d;
      s2_big_q  <= s2_big_d;
      s2_zero_q <= s1_zero_q;
    end
    if (en[2]) begin
      s3_nlog_q <= s3_nlog_d;
      s3_big_q  <= s2_big_q;
      s3_zero_q <= s2_zero_q;
    end
    if (en[3]) begin
      s4_prod_q <= s4_prod_d;
      s4_big_q  <= s3_big_q;
      s4_zero_q <= s3_zero_q;
    end
  end

  // zero floors at -100 dB, >= 1.0 sits at 0 dB, else saturate the loss
  always_comb begin
    if (s4_zero_q) begin
      loss_o = LOSS_MAX;
    end else if (s4_big_q) begin
      loss_o = '0;
    end else if (s4_prod_q[PROD_W-1:PROD_SHIFT] > RAW_W'(LOSS_MAX)) begin
      loss_o = LOSS_MAX;
    end else begin
      loss_o = s4_prod_q[PROD_SHIFT +: LOSS_W];
    end
  end

endmodule

// ===== src/mdbc_color.sv =====
// Three-stage gradient mapper: segment split, per-channel blend, divide by 6400.
module mdbc_color (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mdbc_pkg::LOSS_W-1:0]   loss_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mdbc_pkg::LEVEL_W-1:0]  level_o,
  output logic [mdbc_pkg::CH_W-1:0]     red_o,
  output logic [mdbc_pkg::CH_W-1:0]     green_o,
  output logic [mdbc_pkg::CH_W-1:0]     blue_o
);
  import mdbc_pkg::*;

  logic [2:0] vld_q;
  logic [2:0] en;

  // stage 5: level, segment, position within segment
  logic [LEVEL_W-1:0]  s5_level_q, s5_level_d;
  logic [SEG_W-1:0]    s5_seg_q, s5_seg_d;
  logic [POS_IN_W-1:0] s5_r_q, s5_r_d;
  logic [LOSS_W-1:0]   u, seg_base, r_full;
  // stage 6: blend numerator a*6400 + (b-a)*r
  logic [LEVEL_W-1:0] s6_level_q;
  logic [MIX_W-1:0]   s6_mix_q [NUM_CH];
  logic [MIX_W-1:0]   s6_mix_d [NUM_CH];
  // stage 7: output register
  logic [LEVEL_W-1:0] s7_level_q;
  logic [CH_W-1:0]    s7_ch_q [NUM_CH];
  logic [CH_W-1:0]    s7_ch_d [NUM_CH];

  always_comb begin
    en[2] = ~vld_q[2] | out_ready_i;
    en[1] = ~vld_q[1] | en[2];
    en[0] = ~vld_q[0] | en[1];
  end
  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      if (en[1]) vld_q[1] <= vld_q[0];
      if (en[2]) vld_q[2] <= vld_q[1];
    end
  end

  // top of range (u = 25600) folds into the last quarter with r = 6400
  always_comb begin
    u = LOSS_MAX - loss_i;
    if (u >= LOSS_W'(3 * 6400)) begin
      s5_seg_d = SEG_W'(3);
      seg_base = LOSS_W'(3 * 6400);
    end else if (u >= LOSS_W'(2 * 6400)) begin
      s5_seg_d = SEG_W'(2);
      seg_base = LOSS_W'(2 * 6400);
    end else if (u >= QUARTER) begin
      s5_seg_d = SEG_W'(1);
      seg_base = QUARTER;
    end else begin
      s5_seg_d = SEG_W'(0);
      seg_base = '0;
    end
    r_full     = u - seg_base;
    s5_r_d     = r_full[POS_IN_W-1:0];
    s5_level_d = LEVEL_W'(0) - {1'b0, loss_i};
  end

  // numerator is never negative: it lies between 6400*a and 6400*b
  always_comb begin
    logic [CH_W-1:0]     a, b;
    logic signed [8:0]   diff;
    logic signed [22:0]  term;
    logic [MIX_W-1:0]    base;
    logic signed [23:0]  mix;
    for (int c = 0; c < NUM_CH; c++) begin
      a    = STOP_RGB[s5_seg_q][c];
      b    = STOP_RGB[{1'b0, s5_seg_q} + 3'd1][c];
      diff = $signed({1'b0, b}) - $signed({1'b0, a});
      term = diff * $signed({1'b0, s5_r_q});
      base = MIX_W'(a) * MIX_W'(QUARTER);
      mix  = $signed({3'b000, base}) + 24'(term);
      s6_mix_d[c] = mix[MIX_W-1:0];
    end
  end

  always_comb begin
    logic [QUO_W-1:0] quo;
    for (int c = 0; c < NUM_CH; c++) begin
      quo        = QUO_W'(s6_mix_q[c][MIX_W-1:QUO_SHIFT]) * QUO_W'(RECIP_25);
      s7_ch_d[c] = quo[RECIP_SHIFT +: CH_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s5_level_q <= s5_level_d;
      s5_seg_q   <= s5_seg_d;
      s5_r_q     <= s5_r_d;
    end
    if (en[1]) begin
      s6_level_q <= s5_level_q;
      s6_mix_q   <= s6_mix_d;
    end
    if (en[2]) begin
      s7_level_q <= s6_level_q;
      s7_ch_q    <= s7_ch_d;
    end
  end

  assign level_o = s7_level_q;
  assign red_o   = s7_ch_q[0];
  assign green_o = s7_ch_q[1];
  assign blue_o  = s7_ch_q[2];

endmodule

// ===== src/magnitude_db_colormap_core.sv =====
// Top level of the magnitude dB colormap: log pipeline feeding the gradient pipeline.
//
// Usage:
//   s_axis carries one spectral magnitude per transaction (unsigned Q8.24).
//   m_axis returns one transaction per input: level in dB (signed Q8.8,
//   -100..0 dB) and an 8-bit RGB color on a five-stop gradient.
//   Zero magnitude reads as -100 dB; magnitudes at or above 1.0 read as 0 dB.
// Timing:
//   Seven register stages, in order leading one -> normalize -> log table ->
//   dB multiply -> segment split -> channel blend -> divide by 6400; the
//   last one is the output register. One transaction per cycle sustained
//   while m_axis_tready stays high.
// Flow control:
//   Every stage has its own valid bit and advances when its successor is
//   empty or moving, so bubbles collapse. When m_axis stalls, input is still
//   taken until the pipe is full; then s_axis_tready drops. Nothing is lost
//   or repeated across a stall.
// Reset:
//   rst_ni clears all valid bits; no result is pending after reset. The log
//   table is constant, so there is nothing to fill.
module magnitude_db_colormap_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] magnitude
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [15:0] level_db, [23:16] red, [31:24] green,
                                      // [39:32] blue
);
  import mdbc_pkg::*;

  logic              loss_valid;
  logic              loss_ready;
  logic [LOSS_W-1:0] loss;

  logic [LEVEL_W-1:0] level_db;
  logic [CH_W-1:0]    red, green, blue;

  // magnitude -> saturated dB loss (0..25600, Q8.8)
  mdbc_log u_log (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .mag_i       (s_axis_tdata[MAG_W-1:0]),
    .out_valid_o (loss_valid),
    .out_ready_i (loss_ready),
    .loss_o      (loss)
  );

  // loss -> level and gradient color; last stage is the output register
  mdbc_color u_color (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (loss_valid),
    .in_ready_o  (loss_ready),
    .loss_i      (loss),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .level_o     (level_db),
    .red_o       (red),
    .green_o     (green),
    .blue_o      (blue)
  );

  assign m_axis_tdata = {blue, green, red, level_db};

endmodule

// ===== src/mdbc_checker.sv =====
// Port-level checker for the magnitude dB colormap, bound to the top level.
module mdbc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction changed while stalled");

  // level stays within -100..0 dB
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd0) &&
                      ($signed(m_axis_tdata[15:0]) >= -16'sd25600))
    else $error("level out of range");

  // floor level lands on the first stop
  a_floor_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[15:0] == 16'h9C00) |->
      (m_axis_tdata[39:16] == 24'h2B0012))
    else $error("floor level not on first stop");

  // full scale lands on the last stop
  a_top_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[15:0] == 16'h0000) |->
      (m_axis_tdata[39:16] == 24'h15CCFA))
    else $error("full-scale level not on last stop");

endmodule

bind magnitude_db_colormap_core mdbc_checker u_mdbc_checker (.*);

// ===== test/magnitude_db_colormap_core_tb.sv =====
// Self-checking testbench for magnitude_db_colormap_core: directed corners plus random streams.
module magnitude_db_colormap_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mdbc_pkg::*;

  localparam int          CLK_PERIOD  = 12;
  localparam int          PIPE_DEPTH  = 7;
  localparam int          DRAIN_LIMIT = 20000;
  localparam int          TIMEOUT_NS  = 3_000_000;
  localparam int          RANDOM_ITEMS_PER_PHASE = 100;

  // dB scaling and gradient geometry
  localparam int              LOSS_CAP          = 25600;  // 100 dB in Q8.8
  localparam int              SEG_SPAN          = 6400;   // 25 dB per quarter
  localparam longint unsigned DB_PER_OCTAVE_Q16 = 394566; // 20*log10(2) in Q16

  // dark purple, purple, red, orange, yellow; channels r, g, b
  localparam logic [7:0] GRADIENT [5][3] = '{
    '{8'h12, 8'h00, 8'h2B},
    '{8'h3B, 8'h07, 8'h64},
    '{8'hBE, 8'h12, 8'h3C},
    '{8'hF9, 8'h73, 8'h16},
    '{8'hFA, 8'hCC, 8'h15}
  };

  // Corner magnitudes: zero, leading one below the table index width, the -100, -75,
  // -50 and -25 dB edges, just below / at 1.0 and the top of the input range.
  localparam logic [31:0] CORNER_MAGS [24] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_007F,
    32'h0000_0080, 32'h0000_00FF, 32'h0000_0100, 32'h0000_01FF,
    32'd167,       32'd168,       32'd169,       32'd2983,
    32'd2984,      32'd53054,     32'd53055,     32'd943436,
    32'd943437,    32'h0080_0000, 32'h00C0_0000, 32'h00FF_FFFF,
    32'h0100_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF
  };

  typedef struct packed {
    logic        [7:0]  blue;
    logic        [7:0]  green;
    logic        [7:0]  red;
    logic signed [15:0] level_db;
  } pixel_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [31:0] magnitude
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // [15:0] level_db, [23:16] red, [31:24] green,
                                     // [39:32] blue

  logic [15:0] log2_frac [ROM_DEPTH];  // log2(1 + i/2^LOG_TABLE_BITS), 16 fraction bits
  pixel_t      expected_pixels [$];
  int          fail_count     = 0;
  int          src_idle_pct   = 0;
  int          sink_stall_pct = 0;

  magnitude_db_colormap_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("magnitude_db_colormap_core: mismatch");
    $finish;
  end

  // Leading one -> table lookup -> dB loss, then blend between two gradient stops.
  function automatic pixel_t predict_pixel(input logic [31:0] mag);
    int              p;
    int unsigned     idx;
    longint unsigned nlog;
    longint unsigned loss;
    int              u, seg, pos, a, b;
    pixel_t          px;
    int              blend [3];
    loss = LOSS_CAP;  // zero floors at -100 dB
    if (mag != '0) begin
      p = 31;
      while (!mag[p]) p--;
      if (p >= MAG_FRAC_BITS) begin
        loss = 0;     // at or above 1.0
      end else begin
        if (p >= LOG_TABLE_BITS) idx = (mag >> (p - LOG_TABLE_BITS)) % ROM_DEPTH;
        else                     idx = (mag << (LOG_TABLE_BITS - p)) % ROM_DEPTH;
        nlog = (64'(MAG_FRAC_BITS - p) << 16) - log2_frac[idx];
        loss = (nlog * DB_PER_OCTAVE_Q16) >> 24;
        if (loss > LOSS_CAP) loss = LOSS_CAP;
      end
    end
    u   = LOSS_CAP - int'(loss);
    seg = u / SEG_SPAN;
    if (seg > 3) seg = 3;  // 0 dB sits on the last stop
    pos = u - seg * SEG_SPAN;
    for (int c = 0; c < 3; c++) begin
      a        = GRADIENT[seg][c];
      b        = GRADIENT[seg + 1][c];
      blend[c] = (a * SEG_SPAN + (b - a) * pos) / SEG_SPAN;
    end
    px.level_db = 16'(-int'(loss));
    px.red      = 8'(blend[0]);
    px.green    = 8'(blend[1]);
    px.blue     = 8'(blend[2]);
    return px;
  endfunction

  // Mostly values below 1.0 spread over every leading-one position.
  function automatic logic [31:0] next_magnitude();
    int          kind;
    int          p;
    logic [31:0] mag;
    kind = $urandom_range(0, 15);
    case (kind)
      0: begin
        mag = '0;
      end
      1: begin
        mag = $urandom;
      end
      2: begin
        p   = $urandom_range(MAG_FRAC_BITS, 31);
        mag = (32'd1 << p) | ($urandom & ((32'd1 << p) - 32'd1));
      end
      default: begin
        p   = $urandom_range(0, MAG_FRAC_BITS - 1);
        mag = (32'd1 << p) | ($urandom & ((32'd1 << p) - 32'd1));
      end
    endcase
    return mag;
  endfunction

  // Called at a rising edge; returns at the edge that accepted the transaction.
  task automatic push_magnitude(input logic [31:0] mag);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= mag;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_pixels.push_back(predict_pixel(mag));
  endtask

  task automatic settle_pipeline();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  task automatic stream_random(input int count);
    for (int i = 0; i < count; i++) push_magnitude(next_magnitude());
    settle_pipeline();
  endtask

  task automatic test_corner_levels();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    foreach (CORNER_MAGS[i]) push_magnitude(CORNER_MAGS[i]);
    settle_pipeline();
  endtask

  task automatic test_full_rate();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    stream_random(RANDOM_ITEMS_PER_PHASE);
  endtask

  task automatic test_sparse_source();
    src_idle_pct   = 85;
    sink_stall_pct = 0;
    stream_random(RANDOM_ITEMS_PER_PHASE);
  endtask

  // Fills the pipe so that s_axis_tready has to drop.
  task automatic test_output_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 85;
    stream_random(RANDOM_ITEMS_PER_PHASE);
  endtask

  task automatic test_light_jitter();
    src_idle_pct   = 9;
    sink_stall_pct = 9;
    stream_random(RANDOM_ITEMS_PER_PHASE);
  endtask

  task automatic check_field(input string what, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  // Receiver: ready drawn fresh every cycle.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Each output transaction is matched against the oldest prediction.
  always @(posedge clk_i) begin
    pixel_t got;
    pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_pixels.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got %h", $time, got);
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("level_db", want.level_db, got.level_db);
        check_field("red", {24'd0, want.red}, {24'd0, got.red});
        check_field("green", {24'd0, want.green}, {24'd0, got.green});
        check_field("blue", {24'd0, want.blue}, {24'd0, got.blue});
      end
    end
  end

  initial begin
    logic [63:0] x;
    logic [15:0] f;
    // log table by repeated squaring of the mantissa in Q2.30
    for (int i = 0; i < ROM_DEPTH; i++) begin
      x = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
      f = '0;
      for (int k = 0; k < 16; k++) begin
        x = (x * x) >> 30;
        f = {f[14:0], 1'b0};
        if (x >= (64'd2 << 30)) begin
          f[0] = 1'b1;
          x    = x >> 1;
        end
      end
      log2_frac[i] = f;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_corner_levels();
    test_full_rate();
    test_sparse_source();
    test_output_backpressure();
    test_light_jitter();

    if (expected_pixels.size() != 0) begin
      $display("%0t ns: %0d results expected, none arrived", $time,
               expected_pixels.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("magnitude_db_colormap_core: match");
    end else begin
      $display("magnitude_db_colormap_core: mismatch");
    end
    $finish;
  end

endmodule
